FILE: sv/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on a named clock and active-low reset
`define CTLP_ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ctlp assertion failed");

// same, on the default clock and reset names
`define CTLP_ASSERT(label, prop) `CTLP_ASSERT_CLK(label, clk_i, rst_ni, prop)

`endif

FILE: sv/ctlp_pkg.sv
// types, codes, character constants and helpers for the cnf text parser
package ctlp_pkg;

  localparam int unsigned LITERAL_BITS_DEFAULT = 32;
  localparam int unsigned COUNT_BITS_DEFAULT   = 32;
  localparam int unsigned RESULT_FIFO_DEPTH    = 4;
  localparam int unsigned ENTRY_W_DEFAULT      =
    2 + LITERAL_BITS_DEFAULT + 2 * COUNT_BITS_DEFAULT + 3 + 1;

  typedef enum logic [3:0] {
    PH_LINE_START, PH_COMMENT, PH_PRE_TOKEN, PH_TOKEN, PH_PRE_VARS, PH_VARS,
    PH_PRE_CLS, PH_CLS, PH_REST, PH_BAD, PH_BODY_WS, PH_BODY_NUM, PH_STOPPED
  } phase_e;

  typedef enum logic [1:0] {
    KIND_HEADER, KIND_LITERAL, KIND_DONE, KIND_ERROR
  } kind_e;

  typedef enum logic [2:0] {
    ERR_UNEXPECTED_END, ERR_NO_PROBLEM, ERR_BAD_HEADER, ERR_RANGE,
    ERR_BAD_CHAR, ERR_FEWER, ERR_MORE
  } error_e;

  typedef struct packed {
    phase_e     phase;
    logic [1:0] pos;
    logic       ovf;
    logic       neg;
    logic       dig;
  } parse_ctrl_t;

  localparam parse_ctrl_t CTRL_RESET = '{
    phase: PH_LINE_START, pos: 2'd0, ovf: 1'b0, neg: 1'b0, dig: 1'b0
  };

  localparam logic [1:0] LAST_TOKEN_POS = 2'd3;

  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_N     = 8'h6e;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[CH_ZERO:CH_NINE]};
  endfunction

  function automatic logic is_sign(input logic [7:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS);
  endfunction

  // expected character of the "cnf" token at a match position
  function automatic logic [7:0] cnf_char(input logic [1:0] pos);
    logic [7:0] ch;
    case (pos)
      2'd0:    ch = CH_C;
      2'd1:    ch = CH_N;
      default: ch = CH_F;
    endcase
    return ch;
  endfunction

endpackage

FILE: sv/cnf_text_literal_parser.sv
// top level of the cnf text parser: input register, parser and result queue
//
// Reads a DIMACS CNF text one byte per transfer on the input channel
// (text_byte_i, end_of_text_i marks the final byte). Leading comment lines
// are skipped, the "p cnf V C" header gives a header result, then every
// signed literal gives a literal result and the final byte gives a finished
// or error result. After an error, bytes are dropped up to the final byte.
// A byte causes zero, one or two results; last_of_run_o marks the last one.
// Throughput: one byte per cycle while in_stall_o is low; the parser step sits between
// the input register and the result queue; results leave at one per cycle while
// out_stall_i is low. A transferred byte is held in the input register until its
// results are written into the result queue, from which they are offered.
// The result queue holds four entries; the input stalls while fewer than two
// are free, so a stalled receiver backs up into in_stall_o after a few bytes.
// Reset puts the parser at the start of a new text with an empty queue; the
// final byte of a text also returns the parser to that state.
module cnf_text_literal_parser #(
  parameter int unsigned LITERAL_BITS = ctlp_pkg::LITERAL_BITS_DEFAULT,
  parameter int unsigned COUNT_BITS   = ctlp_pkg::COUNT_BITS_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     text_byte_i,
  input  logic                           end_of_text_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [1:0]                     item_kind_o,
  output logic signed [LITERAL_BITS-1:0] literal_value_o,
  output logic [COUNT_BITS-1:0]          variable_count_o,
  output logic [COUNT_BITS-1:0]          clause_count_o,
  output logic [2:0]                     error_code_o,
  output logic                           last_of_run_o
);

  localparam int unsigned ERR_LSB  = 1;
  localparam int unsigned CLS_LSB  = 4;
  localparam int unsigned VARS_LSB = CLS_LSB + COUNT_BITS;
  localparam int unsigned LIT_LSB  = VARS_LSB + COUNT_BITS;
  localparam int unsigned KIND_LSB = LIT_LSB + LITERAL_BITS;
  localparam int unsigned ENTRY_W  = KIND_LSB + 2;

  logic               in_valid_q, in_valid_d;
  logic [7:0]         byte_q;
  logic               eot_q;
  logic               accept, step, room;
  logic [1:0]         push_cnt;
  logic [ENTRY_W-1:0] entry0, entry1, head;

  assign step       = in_valid_q && room;
  assign in_stall_o = in_valid_q && !room;
  assign accept     = in_valid_i && !in_stall_o;
  assign in_valid_d = accept ? 1'b1 : (step ? 1'b0 : in_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= text_byte_i;
      eot_q  <= end_of_text_i;
    end
  end

  ctlp_parser #(
    .LITERAL_BITS(LITERAL_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .text_byte_i  (byte_q),
    .end_of_text_i(eot_q),
    .push_cnt_o   (push_cnt),
    .entry0_o     (entry0),
    .entry1_o     (entry1)
  );

  ctlp_result_fifo #(
    .WIDTH(ENTRY_W),
    .DEPTH(ctlp_pkg::RESULT_FIFO_DEPTH)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_cnt_i(push_cnt),
    .data0_i   (entry0),
    .data1_i   (entry1),
    .pop_i     (!out_stall_i),
    .valid_o   (out_valid_o),
    .room_o    (room),
    .head_o    (head)
  );

  assign item_kind_o      = head[KIND_LSB +: 2];
  assign literal_value_o  = $signed(head[LIT_LSB +: LITERAL_BITS]);
  assign variable_count_o = head[VARS_LSB +: COUNT_BITS];
  assign clause_count_o   = head[CLS_LSB +: COUNT_BITS];
  assign error_code_o     = head[ERR_LSB +: 3];
  assign last_of_run_o    = head[0];

endmodule

FILE: sv/ctlp_parser.sv
// parser state and one-byte step logic, producing up to two packed results
module ctlp_parser #(
  parameter int unsigned LITERAL_BITS = ctlp_pkg::LITERAL_BITS_DEFAULT,
  parameter int unsigned COUNT_BITS   = ctlp_pkg::COUNT_BITS_DEFAULT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          text_byte_i,
  input  logic                end_of_text_i,
  output logic [1:0]          push_cnt_o,
  output logic [2+LITERAL_BITS+2*COUNT_BITS+3:0] entry0_o,
  output logic [2+LITERAL_BITS+2*COUNT_BITS+3:0] entry1_o
);

  localparam int unsigned MAG_W   = (LITERAL_BITS > COUNT_BITS) ? LITERAL_BITS : COUNT_BITS;
  localparam int unsigned PROD_W  = MAG_W + 4;
  localparam int unsigned ENTRY_W = 2 + LITERAL_BITS + 2 * COUNT_BITS + 3 + 1;
  localparam logic [PROD_W-1:0] LIT_LIM = PROD_W'(1) << (LITERAL_BITS - 1);
  localparam logic [PROD_W-1:0] CNT_LIM = (PROD_W'(1) << COUNT_BITS) - PROD_W'(1);
  localparam logic [MAG_W-1:0]  LIT_MAX = MAG_W'(LIT_LIM - PROD_W'(1));

  typedef struct packed {
    logic              s_hdr;
    logic              s_lit;
    logic              s_fail;
    ctlp_pkg::error_e  s_code;
    logic              e_lit;
    logic              e_fail;
    ctlp_pkg::error_e  e_code;
    logic              e_done;
  } event_t;

  ctlp_pkg::parse_ctrl_t ctrl_q, ctrl_d;
  logic [MAG_W-1:0]      mag_q, mag_d;
  logic [COUNT_BITS-1:0] hv_q, hv_d, hc_q, hc_d, zc_q, zc_d;

  event_t                  ev;
  logic [LITERAL_BITS-1:0] s_val, e_val;
  logic [COUNT_BITS-1:0]   ev_hv, ev_hc, ev_zc;

  logic                base_zero, base_ovf, body_phase;
  logic [MAG_W-1:0]    base_mag, acc_mag;
  logic [PROD_W-1:0]   prod, lim;
  logic                acc_ovf;
  logic [7:0]          c;

  function automatic logic lit_bad(input logic [MAG_W-1:0] mag, input logic ovf,
                                   input logic neg);
    return ovf || (!neg && (mag > LIT_MAX));
  endfunction

  function automatic logic [LITERAL_BITS-1:0] lit_value(input logic [MAG_W-1:0] mag,
                                                        input logic neg);
    logic [MAG_W-1:0] v;
    v = neg ? (MAG_W'(0) - mag) : mag;
    return v[LITERAL_BITS-1:0];
  endfunction

  function automatic logic [ENTRY_W-1:0] pack(input ctlp_pkg::kind_e k,
                                              input logic [LITERAL_BITS-1:0] l,
                                              input logic [COUNT_BITS-1:0] v,
                                              input logic [COUNT_BITS-1:0] cl,
                                              input ctlp_pkg::error_e e);
    return {k, l, v, cl, e, 1'b0};
  endfunction

  assign c = text_byte_i;

  // digit accumulation: magnitude * 10 + digit, checked against the phase limit
  assign base_zero  = (ctrl_q.phase == ctlp_pkg::PH_PRE_VARS) ||
                      (ctrl_q.phase == ctlp_pkg::PH_PRE_CLS) ||
                      (ctrl_q.phase == ctlp_pkg::PH_BODY_WS);
  assign body_phase = (ctrl_q.phase == ctlp_pkg::PH_BODY_WS) ||
                      (ctrl_q.phase == ctlp_pkg::PH_BODY_NUM);
  assign base_mag   = base_zero ? '0 : mag_q;
  assign base_ovf   = base_zero ? 1'b0 : ctrl_q.ovf;
  assign prod       = (PROD_W'(base_mag) << 3) + (PROD_W'(base_mag) << 1) +
                      PROD_W'(c[3:0]);
  assign lim        = body_phase ? LIT_LIM : CNT_LIM;
  assign acc_ovf    = base_ovf || (prod > lim);
  assign acc_mag    = acc_ovf ? base_mag : prod[MAG_W-1:0];

  // next state and result events
  always_comb begin
    ctrl_d = ctrl_q;
    mag_d  = mag_q;
    hv_d   = hv_q;
    hc_d   = hc_q;
    zc_d   = zc_q;
    ev     = '0;
    s_val  = '0;
    e_val  = '0;

    case (ctrl_q.phase)
      ctlp_pkg::PH_LINE_START: begin
        if (c == ctlp_pkg::CH_C) begin
          ctrl_d.phase = ctlp_pkg::PH_COMMENT;
        end else if (c == ctlp_pkg::CH_P) begin
          ctrl_d.phase = ctlp_pkg::PH_PRE_TOKEN;
          ctrl_d.pos   = '0;
        end else begin
          ev.s_fail = 1'b1;
          ev.s_code = ctlp_pkg::ERR_NO_PROBLEM;
        end
      end
      ctlp_pkg::PH_COMMENT: begin
        if (c == ctlp_pkg::CH_NL) ctrl_d.phase = ctlp_pkg::PH_LINE_START;
      end
      ctlp_pkg::PH_PRE_TOKEN: begin
        if (c == ctlp_pkg::CH_NL) begin
          ev.s_fail = 1'b1;
          ev.s_code = ctlp_pkg::ERR_BAD_HEADER;
        end else if (!ctlp_pkg::is_ws(c)) begin
          if (c == ctlp_pkg::cnf_char(2'd0)) begin
            ctrl_d.pos   = 2'd1;
            ctrl_d.phase = ctlp_pkg::PH_TOKEN;
          end else begin
            ctrl_d.phase = ctlp_pkg::PH_BAD;
          end
        end
      end
      ctlp_pkg::PH_TOKEN: begin
        if (ctlp_pkg::is_ws(c)) begin
          if (ctrl_q.pos == ctlp_pkg::LAST_TOKEN_POS && c != ctlp_pkg::CH_NL) begin
            ctrl_d.phase = ctlp_pkg::PH_PRE_VARS;
          end else if (c == ctlp_pkg::CH_NL) begin
            ev.s_fail = 1'b1;
            ev.s_code = ctlp_pkg::ERR_BAD_HEADER;
          end else begin
            ctrl_d.phase = ctlp_pkg::PH_BAD;
          end
        end else if (ctrl_q.pos != ctlp_pkg::LAST_TOKEN_POS &&
                     c == ctlp_pkg::cnf_char(ctrl_q.pos)) begin
          ctrl_d.pos = ctrl_q.pos + 2'd1;
        end else begin
          ctrl_d.phase = ctlp_pkg::PH_BAD;
        end
      end
      ctlp_pkg::PH_PRE_VARS, ctlp_pkg::PH_PRE_CLS: begin
        if (ctlp_pkg::is_digit(c)) begin
          mag_d        = acc_mag;
          ctrl_d.ovf   = acc_ovf;
          ctrl_d.dig   = 1'b1;
          ctrl_d.neg   = 1'b0;
          ctrl_d.phase = (ctrl_q.phase == ctlp_pkg::PH_PRE_VARS) ?
                         ctlp_pkg::PH_VARS : ctlp_pkg::PH_CLS;
        end else if (!(ctlp_pkg::is_ws(c) && c != ctlp_pkg::CH_NL)) begin
          if (c == ctlp_pkg::CH_NL) begin
            ev.s_fail = 1'b1;
            ev.s_code = ctlp_pkg::ERR_BAD_HEADER;
          end else begin
            ctrl_d.phase = ctlp_pkg::PH_BAD;
          end
        end
      end
      ctlp_pkg::PH_VARS: begin
        if (ctlp_pkg::is_digit(c)) begin
          mag_d      = acc_mag;
          ctrl_d.ovf = acc_ovf;
          ctrl_d.dig = 1'b1;
        end else if (ctlp_pkg::is_ws(c) && !ctrl_q.ovf) begin
          hv_d = mag_q[COUNT_BITS-1:0];
          if (c == ctlp_pkg::CH_NL) begin
            ev.s_fail = 1'b1;
            ev.s_code = ctlp_pkg::ERR_BAD_HEADER;
          end else begin
            ctrl_d.phase = ctlp_pkg::PH_PRE_CLS;
          end
        end else if (c == ctlp_pkg::CH_NL) begin
          ev.s_fail = 1'b1;
          ev.s_code = ctlp_pkg::ERR_BAD_HEADER;
        end else begin
          ctrl_d.phase = ctlp_pkg::PH_BAD;
        end
      end
      ctlp_pkg::PH_CLS: begin
        if (ctlp_pkg::is_digit(c)) begin
          mag_d      = acc_mag;
          ctrl_d.ovf = acc_ovf;
          ctrl_d.dig = 1'b1;
        end else if (!ctrl_q.ovf) begin
          // any non-digit ends the clause count, the rest of the line is ignored
          hc_d = mag_q[COUNT_BITS-1:0];
          if (c == ctlp_pkg::CH_NL) begin
            ev.s_hdr     = 1'b1;
            ctrl_d.phase = ctlp_pkg::PH_BODY_WS;
          end else begin
            ctrl_d.phase = ctlp_pkg::PH_REST;
          end
        end else if (c == ctlp_pkg::CH_NL) begin
          ev.s_fail = 1'b1;
          ev.s_code = ctlp_pkg::ERR_BAD_HEADER;
        end else begin
          ctrl_d.phase = ctlp_pkg::PH_BAD;
        end
      end
      ctlp_pkg::PH_REST: begin
        if (c == ctlp_pkg::CH_NL) begin
          ev.s_hdr     = 1'b1;
          ctrl_d.phase = ctlp_pkg::PH_BODY_WS;
        end
      end
      ctlp_pkg::PH_BAD: begin
        if (c == ctlp_pkg::CH_NL) begin
          ev.s_fail = 1'b1;
          ev.s_code = ctlp_pkg::ERR_BAD_HEADER;
        end
      end
      ctlp_pkg::PH_BODY_WS: begin
        if (!ctlp_pkg::is_ws(c)) begin
          mag_d      = '0;
          ctrl_d.ovf = 1'b0;
          ctrl_d.neg = 1'b0;
          ctrl_d.dig = 1'b0;
          if (ctlp_pkg::is_digit(c)) begin
            mag_d        = acc_mag;
            ctrl_d.ovf   = acc_ovf;
            ctrl_d.dig   = 1'b1;
            ctrl_d.phase = ctlp_pkg::PH_BODY_NUM;
          end else if (ctlp_pkg::is_sign(c)) begin
            ctrl_d.neg   = (c == ctlp_pkg::CH_MINUS);
            ctrl_d.phase = ctlp_pkg::PH_BODY_NUM;
          end else begin
            ev.s_fail = 1'b1;
            ev.s_code = ctlp_pkg::ERR_BAD_CHAR;
          end
        end
      end
      ctlp_pkg::PH_BODY_NUM: begin
        if (ctlp_pkg::is_digit(c)) begin
          mag_d      = acc_mag;
          ctrl_d.ovf = acc_ovf;
          ctrl_d.dig = 1'b1;
        end else if (!ctrl_q.dig) begin
          ev.s_fail = 1'b1;
          ev.s_code = ctlp_pkg::ERR_BAD_CHAR;
        end else if (lit_bad(mag_q, ctrl_q.ovf, ctrl_q.neg)) begin
          ev.s_fail = 1'b1;
          ev.s_code = ctlp_pkg::ERR_RANGE;
        end else begin
          ev.s_lit     = 1'b1;
          s_val        = lit_value(mag_q, ctrl_q.neg);
          ctrl_d.phase = ctlp_pkg::PH_BODY_WS;
          if (mag_q == '0) zc_d = zc_q + COUNT_BITS'(1);
          // a sign right after digits starts the next literal
          if (ctlp_pkg::is_sign(c)) begin
            mag_d        = '0;
            ctrl_d.ovf   = 1'b0;
            ctrl_d.dig   = 1'b0;
            ctrl_d.neg   = (c == ctlp_pkg::CH_MINUS);
            ctrl_d.phase = ctlp_pkg::PH_BODY_NUM;
          end else if (!ctlp_pkg::is_ws(c)) begin
            ev.s_fail = 1'b1;
            ev.s_code = ctlp_pkg::ERR_BAD_CHAR;
          end
        end
      end
      default: begin
      end
    endcase

    if (ev.s_fail) ctrl_d.phase = ctlp_pkg::PH_STOPPED;

    // final byte: close an open literal, then compare the clause count
    if (end_of_text_i && ctrl_d.phase != ctlp_pkg::PH_STOPPED) begin
      if (ctrl_d.phase == ctlp_pkg::PH_BODY_NUM) begin
        if (!ctrl_d.dig) begin
          ev.e_fail = 1'b1;
          ev.e_code = ctlp_pkg::ERR_BAD_CHAR;
        end else if (lit_bad(mag_d, ctrl_d.ovf, ctrl_d.neg)) begin
          ev.e_fail = 1'b1;
          ev.e_code = ctlp_pkg::ERR_RANGE;
        end else begin
          ev.e_lit     = 1'b1;
          e_val        = lit_value(mag_d, ctrl_d.neg);
          ctrl_d.phase = ctlp_pkg::PH_BODY_WS;
          if (mag_d == '0) zc_d = zc_d + COUNT_BITS'(1);
        end
      end
      if (!ev.e_fail) begin
        if (ctrl_d.phase != ctlp_pkg::PH_BODY_WS) begin
          ev.e_fail = 1'b1;
          ev.e_code = ctlp_pkg::ERR_UNEXPECTED_END;
        end else if (zc_d == hc_d) begin
          ev.e_done = 1'b1;
        end else begin
          ev.e_fail = 1'b1;
          ev.e_code = (zc_d < hc_d) ? ctlp_pkg::ERR_FEWER : ctlp_pkg::ERR_MORE;
        end
      end
    end

    ev_hv = hv_d;
    ev_hc = hc_d;
    ev_zc = zc_d;

    if (end_of_text_i) begin
      ctrl_d = ctlp_pkg::CTRL_RESET;
      mag_d  = '0;
      hv_d   = '0;
      hc_d   = '0;
      zc_d   = '0;
    end
  end

  // result packing in emission order
  logic [ENTRY_W-1:0] ent [2];
  logic [1:0]         n;

  always_comb begin
    ent[0] = '0;
    ent[1] = '0;
    n      = 2'd0;
    if (ev.s_hdr) begin
      ent[n[0]] = pack(ctlp_pkg::KIND_HEADER, '0, ev_hv, ev_hc,
                       ctlp_pkg::ERR_UNEXPECTED_END);
      n = n + 2'd1;
    end
    if (ev.s_lit) begin
      ent[n[0]] = pack(ctlp_pkg::KIND_LITERAL, s_val, '0, '0,
                       ctlp_pkg::ERR_UNEXPECTED_END);
      n = n + 2'd1;
    end
    if (ev.s_fail) begin
      ent[n[0]] = pack(ctlp_pkg::KIND_ERROR, '0, '0, '0, ev.s_code);
      n = n + 2'd1;
    end
    if (ev.e_lit) begin
      ent[n[0]] = pack(ctlp_pkg::KIND_LITERAL, e_val, '0, '0,
                       ctlp_pkg::ERR_UNEXPECTED_END);
      n = n + 2'd1;
    end
    if (ev.e_fail) begin
      ent[n[0]] = pack(ctlp_pkg::KIND_ERROR, '0, '0,
                       (ev.e_code == ctlp_pkg::ERR_FEWER ||
                        ev.e_code == ctlp_pkg::ERR_MORE) ? ev_zc : '0,
                       ev.e_code);
      n = n + 2'd1;
    end
    if (ev.e_done) begin
      ent[n[0]] = pack(ctlp_pkg::KIND_DONE, '0, ev_hv, ev_zc,
                       ctlp_pkg::ERR_UNEXPECTED_END);
      n = n + 2'd1;
    end
    if (n == 2'd1) ent[0][0] = 1'b1;
    if (n == 2'd2) ent[1][0] = 1'b1;
  end

  assign push_cnt_o = step_i ? n : 2'd0;
  assign entry0_o   = ent[0];
  assign entry1_o   = ent[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= ctlp_pkg::CTRL_RESET;
      mag_q  <= '0;
      hv_q   <= '0;
      hc_q   <= '0;
      zc_q   <= '0;
    end else if (step_i) begin
      ctrl_q <= ctrl_d;
      mag_q  <= mag_d;
      hv_q   <= hv_d;
      hc_q   <= hc_d;
      zc_q   <= zc_d;
    end
  end

endmodule

FILE: sv/ctlp_result_fifo.sv
// result queue taking up to two entries per cycle and giving one
module ctlp_result_fifo #(
  parameter int unsigned WIDTH = ctlp_pkg::ENTRY_W_DEFAULT,
  parameter int unsigned DEPTH = ctlp_pkg::RESULT_FIFO_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [1:0]       push_cnt_i,
  input  logic [WIDTH-1:0] data0_i,
  input  logic [WIDTH-1:0] data1_i,
  input  logic             pop_i,
  output logic             valid_o,
  output logic             room_o,
  output logic [WIDTH-1:0] head_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             pop;

  assign pop     = pop_i && valid_o;
  assign valid_o = (cnt_q != '0);
  // room for a two-entry transfer
  assign room_o  = (cnt_q <= CNT_W'(DEPTH - 2));
  assign head_o  = mem_q[rd_q];

  assign wr_d  = wr_q + PTR_W'(push_cnt_i);
  assign rd_d  = rd_q + PTR_W'(pop);
  assign cnt_d = cnt_q + CNT_W'(push_cnt_i) - CNT_W'(pop);

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) mem_q[wr_q] <= data0_i;
    if (push_cnt_i == 2'd2) mem_q[wr_q + PTR_W'(1)] <= data1_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: sv/ctlp_checker.sv
// port-level checker for the cnf text parser, bound to the top level
`include "assert_macros.svh"

module ctlp_checker #(
  parameter int unsigned LITERAL_BITS = ctlp_pkg::LITERAL_BITS_DEFAULT,
  parameter int unsigned COUNT_BITS   = ctlp_pkg::COUNT_BITS_DEFAULT
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [1:0]                     item_kind_o,
  input logic signed [LITERAL_BITS-1:0] literal_value_o,
  input logic [COUNT_BITS-1:0]          variable_count_o,
  input logic [COUNT_BITS-1:0]          clause_count_o,
  input logic [2:0]                     error_code_o,
  input logic                           last_of_run_o
);

  // a stalled result stays offered and unchanged
  `CTLP_ASSERT(a_out_valid_hold, out_valid_o && out_stall_i |=> out_valid_o)
  `CTLP_ASSERT(a_out_payload_hold,
    out_valid_o && out_stall_i |=> $stable(item_kind_o) && $stable(literal_value_o) &&
    $stable(variable_count_o) && $stable(clause_count_o) && $stable(error_code_o) &&
    $stable(last_of_run_o))

  // input stall only rises right after an input transfer
  `CTLP_ASSERT(a_stall_after_transfer, $rose(in_stall_o) |-> $past(in_valid_i && !in_stall_o))

  // an error always closes the run of its byte
  `CTLP_ASSERT_CLK(a_error_ends_run, clk_i, rst_ni,
    out_valid_o && item_kind_o == ctlp_pkg::KIND_ERROR |-> last_of_run_o)

  // only literal results carry a literal value
  `CTLP_ASSERT(a_value_only_literal,
    out_valid_o && item_kind_o != ctlp_pkg::KIND_LITERAL |-> literal_value_o == '0)

endmodule

bind cnf_text_literal_parser ctlp_checker #(
  .LITERAL_BITS(LITERAL_BITS),
  .COUNT_BITS  (COUNT_BITS)
) u_ctlp_checker (.*);

FILE: bench/cnf_text_literal_parser_test.sv
// self-checking testbench for the cnf text parser: byte stimulus, result prediction and checks

class cnf_parse_scoreboard;
  typedef struct {
    ctlp_pkg::kind_e  kind;
    logic [31:0]      literal;
    logic [31:0]      variables;
    logic [31:0]      clauses;
    ctlp_pkg::error_e code;
    logic             last;
  } parse_result_t;

  localparam logic [63:0] COUNT_MAX     = 64'hFFFF_FFFF;
  localparam logic [63:0] LITERAL_LIMIT = 64'h8000_0000;

  parse_result_t pending_results[$];
  int            failures;

  ctlp_pkg::phase_e phase;
  logic [1:0]       match_pos;
  logic [63:0]      magnitude;
  logic             too_big;
  logic             negative;
  logic             have_digits;
  logic [31:0]      header_vars;
  logic [31:0]      header_clauses;
  logic [31:0]      zero_count;

  function new();
    failures = 0;
    clear();
  endfunction

  static function bit blank_char(logic [7:0] c);
    return c == ctlp_pkg::CH_SPACE || (c >= 8'd9 && c <= 8'd13);
  endfunction

  static function bit digit_char(logic [7:0] c);
    return c >= ctlp_pkg::CH_ZERO && c <= ctlp_pkg::CH_NINE;
  endfunction

  static function bit sign_char(logic [7:0] c);
    return c == ctlp_pkg::CH_PLUS || c == ctlp_pkg::CH_MINUS;
  endfunction

  function void start_number();
    magnitude   = '0;
    too_big     = 1'b0;
    negative    = 1'b0;
    have_digits = 1'b0;
  endfunction

  function void clear();
    phase          = ctlp_pkg::PH_LINE_START;
    match_pos      = 2'd0;
    header_vars    = '0;
    header_clauses = '0;
    zero_count     = '0;
    start_number();
  endfunction

  function void push(ctlp_pkg::kind_e kind, logic [31:0] lit, logic [31:0] vars,
                     logic [31:0] cls, ctlp_pkg::error_e code);
    parse_result_t r;
    r.kind      = kind;
    r.literal   = lit;
    r.variables = vars;
    r.clauses   = cls;
    r.code      = code;
    r.last      = 1'b0;
    pending_results.insert(pending_results.size(), r);
  endfunction

  function void stop_with(ctlp_pkg::error_e code);
    logic [31:0] cls;
    cls = (code == ctlp_pkg::ERR_FEWER || code == ctlp_pkg::ERR_MORE) ? zero_count : 32'd0;
    push(ctlp_pkg::KIND_ERROR, '0, '0, cls, code);
    phase = ctlp_pkg::PH_STOPPED;
  endfunction

  function void add_digit(logic [63:0] limit, logic [7:0] c);
    logic [63:0] d;
    d = 64'(c - ctlp_pkg::CH_ZERO);
    have_digits = 1'b1;
    if (!too_big) begin
      if (magnitude > (limit - d) / 64'd10) too_big = 1'b1;
      else magnitude = magnitude * 64'd10 + d;
    end
  endfunction

  function void header_fault(logic [7:0] c);
    if (c == ctlp_pkg::CH_NL) stop_with(ctlp_pkg::ERR_BAD_HEADER);
    else phase = ctlp_pkg::PH_BAD;
  endfunction

  function void header_done();
    push(ctlp_pkg::KIND_HEADER, '0, header_vars, header_clauses,
         ctlp_pkg::ERR_UNEXPECTED_END);
    phase = ctlp_pkg::PH_BODY_WS;
  endfunction

  // emits the literal that just ended, false when it is out of range
  function bit close_literal();
    logic [63:0] value;
    if (too_big || (!negative && magnitude > LITERAL_LIMIT - 64'd1)) begin
      stop_with(ctlp_pkg::ERR_RANGE);
      return 1'b0;
    end
    value = negative ? 64'd0 - magnitude : magnitude;
    if (magnitude == 64'd0) zero_count = zero_count + 32'd1;
    push(ctlp_pkg::KIND_LITERAL, value[31:0], '0, '0, ctlp_pkg::ERR_UNEXPECTED_END);
    phase = ctlp_pkg::PH_BODY_WS;
    return 1'b1;
  endfunction

  function void advance(logic [7:0] c);
    case (phase)
      ctlp_pkg::PH_LINE_START: begin
        if (c == ctlp_pkg::CH_C) phase = ctlp_pkg::PH_COMMENT;
        else if (c == ctlp_pkg::CH_P) begin
          phase     = ctlp_pkg::PH_PRE_TOKEN;
          match_pos = 2'd0;
        end else stop_with(ctlp_pkg::ERR_NO_PROBLEM);
      end
      ctlp_pkg::PH_COMMENT: begin
        if (c == ctlp_pkg::CH_NL) phase = ctlp_pkg::PH_LINE_START;
      end
      ctlp_pkg::PH_PRE_TOKEN: begin
        if (c == ctlp_pkg::CH_NL) stop_with(ctlp_pkg::ERR_BAD_HEADER);
        else if (!blank_char(c)) begin
          if (c == ctlp_pkg::CH_C) begin
            match_pos = 2'd1;
            phase     = ctlp_pkg::PH_TOKEN;
          end else phase = ctlp_pkg::PH_BAD;
        end
      end
      ctlp_pkg::PH_TOKEN: begin
        if (blank_char(c)) begin
          if (match_pos == ctlp_pkg::LAST_TOKEN_POS && c != ctlp_pkg::CH_NL)
            phase = ctlp_pkg::PH_PRE_VARS;
          else header_fault(c);
        end else if (match_pos != ctlp_pkg::LAST_TOKEN_POS &&
                     c == ((match_pos == 2'd0) ? ctlp_pkg::CH_C :
                           (match_pos == 2'd1) ? ctlp_pkg::CH_N : ctlp_pkg::CH_F)) begin
          match_pos = match_pos + 2'd1;
        end else phase = ctlp_pkg::PH_BAD;
      end
      ctlp_pkg::PH_PRE_VARS, ctlp_pkg::PH_PRE_CLS: begin
        if (digit_char(c)) begin
          start_number();
          add_digit(COUNT_MAX, c);
          if (phase == ctlp_pkg::PH_PRE_VARS) phase = ctlp_pkg::PH_VARS;
          else phase = ctlp_pkg::PH_CLS;
        end else if (!blank_char(c) || c == ctlp_pkg::CH_NL) header_fault(c);
      end
      ctlp_pkg::PH_VARS: begin
        if (digit_char(c)) add_digit(COUNT_MAX, c);
        else if (blank_char(c) && !too_big) begin
          header_vars = magnitude[31:0];
          if (c == ctlp_pkg::CH_NL) stop_with(ctlp_pkg::ERR_BAD_HEADER);
          else phase = ctlp_pkg::PH_PRE_CLS;
        end else header_fault(c);
      end
      ctlp_pkg::PH_CLS: begin
        // any non-digit ends the clause count, the rest of the line is skipped
        if (digit_char(c)) add_digit(COUNT_MAX, c);
        else if (too_big) header_fault(c);
        else begin
          header_clauses = magnitude[31:0];
          if (c == ctlp_pkg::CH_NL) header_done();
          else phase = ctlp_pkg::PH_REST;
        end
      end
      ctlp_pkg::PH_REST: begin
        if (c == ctlp_pkg::CH_NL) header_done();
      end
      ctlp_pkg::PH_BAD: begin
        if (c == ctlp_pkg::CH_NL) stop_with(ctlp_pkg::ERR_BAD_HEADER);
      end
      ctlp_pkg::PH_BODY_WS: begin
        if (!blank_char(c)) begin
          start_number();
          if (digit_char(c)) begin
            add_digit(LITERAL_LIMIT, c);
            phase = ctlp_pkg::PH_BODY_NUM;
          end else if (sign_char(c)) begin
            negative = (c == ctlp_pkg::CH_MINUS);
            phase    = ctlp_pkg::PH_BODY_NUM;
          end else stop_with(ctlp_pkg::ERR_BAD_CHAR);
        end
      end
      ctlp_pkg::PH_BODY_NUM: begin
        if (digit_char(c)) add_digit(LITERAL_LIMIT, c);
        else if (!have_digits) stop_with(ctlp_pkg::ERR_BAD_CHAR);
        else if (close_literal()) begin
          // a sign right after digits opens the next literal
          if (sign_char(c)) begin
            start_number();
            negative = (c == ctlp_pkg::CH_MINUS);
            phase    = ctlp_pkg::PH_BODY_NUM;
          end else if (!blank_char(c)) stop_with(ctlp_pkg::ERR_BAD_CHAR);
        end
      end
      default: ;
    endcase
  endfunction

  function void close_text();
    if (phase == ctlp_pkg::PH_STOPPED) return;
    if (phase == ctlp_pkg::PH_BODY_NUM) begin
      if (!have_digits) begin
        stop_with(ctlp_pkg::ERR_BAD_CHAR);
        return;
      end
      if (!close_literal()) return;
    end
    if (phase != ctlp_pkg::PH_BODY_WS) stop_with(ctlp_pkg::ERR_UNEXPECTED_END);
    else if (zero_count == header_clauses)
      push(ctlp_pkg::KIND_DONE, '0, header_vars, zero_count, ctlp_pkg::ERR_UNEXPECTED_END);
    else if (zero_count < header_clauses) stop_with(ctlp_pkg::ERR_FEWER);
    else stop_with(ctlp_pkg::ERR_MORE);
  endfunction

  // called for every accepted input transfer
  function void note_byte(logic [7:0] c, logic eot);
    int            before_count;
    parse_result_t tail;
    before_count = pending_results.size();
    advance(c);
    if (eot) begin
      close_text();
      clear();
    end
    if (pending_results.size() > before_count) begin
      tail      = pending_results.pop_back();
      tail.last = 1'b1;
      pending_results.insert(pending_results.size(), tail);
    end
  endfunction

  function bit field_ok(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // called for every accepted output transfer
  function void check_result(logic [1:0] kind, logic [31:0] lit, logic [31:0] vars,
                             logic [31:0] cls, logic [2:0] code, logic last);
    parse_result_t want;
    bit            good;
    if (pending_results.size() == 0) begin
      $display("%0t: result kind %0d literal %0h arrived with none expected",
               $time, kind, lit);
      failures++;
      return;
    end
    want = pending_results.pop_front();
    good = field_ok("item_kind", 32'(want.kind), 32'(kind));
    good &= field_ok("literal_value", want.literal, lit);
    good &= field_ok("variable_count", want.variables, vars);
    good &= field_ok("clause_count", want.clauses, cls);
    good &= field_ok("error_code", 32'(want.code), 32'(code));
    good &= field_ok("last_of_run", 32'(want.last), 32'(last));
    if (!good) failures++;
  endfunction
endclass

module cnf_text_literal_parser_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT  = 3000;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AT      = 1000;
  localparam int RANDOM_BYTES = 1400;
  localparam int DRAIN_CYCLES = 8;
  localparam int MODE_LENGTH  = 250;

  typedef struct packed {
    logic       eot;
    logic [7:0] ch;
  } text_item_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid    = 1'b0;
  logic [7:0]  text_byte   = 8'h00;
  logic        end_of_text = 1'b0;
  logic        out_stall   = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [1:0]  item_kind;
  logic signed [31:0] literal_value;
  logic [31:0] variable_count;
  logic [31:0] clause_count;
  logic [2:0]  error_code;
  logic        last_of_run;

  logic        hold_req  = 1'b0;
  int          idle_mode = 0;

  logic [7:0]  draft[$];
  text_item_t  stream[$];

  cnf_parse_scoreboard sb = new();

  always #2 clk_i = ~clk_i;

  cnf_text_literal_parser u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .text_byte_i     (text_byte),
    .end_of_text_i   (end_of_text),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .item_kind_o     (item_kind),
    .literal_value_o (literal_value),
    .variable_count_o(variable_count),
    .clause_count_o  (clause_count),
    .error_code_o    (error_code),
    .last_of_run_o   (last_of_run)
  );

  function automatic void add_char(logic [7:0] ch);
    draft.insert(draft.size(), ch);
  endfunction

  function automatic void put(string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
  endfunction

  // the last byte of a text carries end_of_text
  function automatic void commit_draft();
    if (draft.size() == 0) add_char(8'($urandom_range(255)));
    foreach (draft[i])
      stream.insert(stream.size(), '{eot: (i == draft.size() - 1), ch: draft[i]});
    draft.delete();
  endfunction

  function automatic void add_text(string s);
    put(s);
    commit_draft();
  endfunction

  function automatic logic [7:0] gap_char();
    int r;
    r = $urandom_range(99);
    if (r < 60) return ctlp_pkg::CH_SPACE;
    if (r < 72) return ctlp_pkg::CH_TAB;
    if (r < 90) return ctlp_pkg::CH_NL;
    if (r < 94) return 8'h0b;
    if (r < 97) return 8'h0c;
    return ctlp_pkg::CH_CR;
  endfunction

  // whitespace that stays on the header line
  function automatic void put_line_gap();
    int r;
    repeat ($urandom_range(2, 1)) begin
      r = $urandom_range(99);
      if (r < 70) add_char(ctlp_pkg::CH_SPACE);
      else if (r < 85) add_char(ctlp_pkg::CH_TAB);
      else if (r < 90) add_char(8'h0b);
      else if (r < 95) add_char(8'h0c);
      else add_char(ctlp_pkg::CH_CR);
    end
  endfunction

  function automatic string count_token();
    int          r;
    logic [63:0] value;
    r = $urandom_range(99);
    if (r < 85) value = 64'($urandom_range(60));
    else if (r < 91) value = 64'hFFFF_FFFF;
    else if (r < 96) value = 64'($urandom);
    else value = 64'h1_0000_0000 + 64'($urandom_range(1000));
    return $sformatf("%0d", value);
  endfunction

  function automatic string literal_token();
    int          r;
    logic [63:0] mag;
    string       head;
    r = $urandom_range(99);
    if (r < 90) mag = 64'($urandom_range(60, 1));
    else if (r < 92) mag = 64'd2147483647;
    else if (r < 94) mag = 64'd2147483648;
    else if (r < 97) mag = 64'($urandom);
    else if (r < 99) mag = 64'd2147483649 + 64'($urandom_range(1000));
    else mag = {$urandom, $urandom};
    head = $urandom_range(1) ? "-" : (($urandom_range(9) == 0) ? "+" : "");
    if ($urandom_range(9) == 0) head = {head, "00"};
    return {head, $sformatf("%0d", mag)};
  endfunction

  function automatic string zero_token();
    int r;
    r = $urandom_range(99);
    if (r < 85) return "0";
    if (r < 90) return "-0";
    if (r < 95) return "+0";
    return "00";
  endfunction

  function automatic void put_token(string tok);
    logic glued;
    glued = draft.size() != 0 && draft[$] >= ctlp_pkg::CH_ZERO &&
            draft[$] <= ctlp_pkg::CH_NINE &&
            (tok[0] == ctlp_pkg::CH_PLUS || tok[0] == ctlp_pkg::CH_MINUS) &&
            $urandom_range(3) == 0;
    if (!glued) add_char(gap_char());
    put(tok);
  endfunction

  function automatic void add_random_text();
    int         r;
    int         nclauses;
    int         cls;
    int         keep;
    logic [7:0] junk;
    r = $urandom_range(99);
    if (r < 8) begin
      repeat ($urandom_range(6, 1)) add_char(8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(2)) begin
        put("c");
        repeat ($urandom_range(8)) begin
          junk = 8'($urandom_range(255));
          add_char((junk == ctlp_pkg::CH_NL) ? ctlp_pkg::CH_SPACE : junk);
        end
        add_char(ctlp_pkg::CH_NL);
      end
      nclauses = $urandom_range(5);
      cls = nclauses;
      if ($urandom_range(9) == 0) cls = nclauses + 1;
      else if ($urandom_range(9) == 0 && nclauses > 0) cls = nclauses - 1;
      put("p");
      put_line_gap();
      put("cnf");
      put_line_gap();
      put(count_token());
      put_line_gap();
      put($sformatf("%0d", cls));
      if ($urandom_range(7) == 0) begin
        put_line_gap();
        put("x 9");
      end
      add_char(ctlp_pkg::CH_NL);
      repeat (nclauses) begin
        repeat ($urandom_range(4)) put_token(literal_token());
        put_token(zero_token());
      end
      // an optional whitespace byte follows the last clause end digit or the header line
      if ($urandom_range(1)) add_char(gap_char());
      r = $urandom_range(99);
      if (r < 10) draft[$urandom_range(draft.size() - 1)] = 8'($urandom_range(255));
      else if (r < 15) draft.insert($urandom_range(draft.size() - 1), 8'($urandom_range(255)));
      else if (r < 20) begin
        keep = $urandom_range(draft.size(), 1);
        while (draft.size() > keep) void'(draft.pop_back());
      end
    end
    commit_draft();
  endfunction

  function automatic void build_stimulus();
    int directed_size;
    add_text("p cnf 4294967295 2\n-2147483648 2147483647 0 -0\n");
    add_text("c skip\np\tcnf 0 0\n");
    add_text("\n");
    add_char(8'h00);
    commit_draft();
    add_text("c only");
    add_text("p cnf 4294967296 1\n");
    add_text("p cnf 1 -1\n");
    add_text("p cnf 7\n");
    add_text("p cnx 1 1\n");
    add_text("p cnf 2 1");
    add_text("p cnf 1 1\n2147483648 0\n");
    add_text("p cnf 1 1\n-2147483649 0\n");
    add_text("p cnf 1 1\n1-1+0");
    add_text("p cnf 1 1\n- 0\n");
    add_text("p cnf 1 1\n1x\n");
    put("p cnf 1 1\n");
    add_char(8'hff);
    commit_draft();
    add_text("p cnf 1 1\n-");
    add_text("p cnf 1 2\n0\n");
    add_text("p cnf 1 0\n0 0");
    add_text("p cnf 3 1 trailing\n0\n");
    directed_size = stream.size();
    while (stream.size() < directed_size + RANDOM_BYTES) add_random_text();
  endfunction

  initial begin : sender
    int sent;
    int pct;
    sent = 0;
    build_stimulus();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (stream[i]) begin
      idle_mode = (sent / MODE_LENGTH) % 4;
      pct = (idle_mode == 1) ? 61 : (idle_mode == 3) ? 21 : 0;
      if (pct != 0 && $urandom_range(99) < pct) begin
        in_valid <= 1'b0;
        do @(posedge clk_i); while ($urandom_range(99) < pct);
      end
      in_valid    <= 1'b1;
      text_byte   <= stream[i].ch;
      end_of_text <= stream[i].eot;
      do @(posedge clk_i); while (in_stall);
      sb.note_byte(stream[i].ch, stream[i].eot);
      sent++;
      // long receiver hold-off while bytes keep coming
      if (sent == HOLD_AT) hold_req = 1'b1;
    end
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.failures == 0 && sb.pending_results.size() == 0) begin
      $display("cnf_text_literal_parser_test: PASS");
    end else begin
      $display("cnf_text_literal_parser_test: FAIL");
    end
    $finish;
  end

  initial begin : receiver
    int hold_left;
    int pct;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid && !out_stall)
        sb.check_result(item_kind, literal_value, variable_count, clause_count, error_code,
                        last_of_run);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      pct = (idle_mode == 2) ? 61 : (idle_mode == 3) ? 21 : 0;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= (pct != 0) && ($urandom_range(99) < pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("cnf_text_literal_parser_test: FAIL");
    $finish;
  end
endmodule
